// File: rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared constants, types and controller/datapath interfaces for the
// nearest point search block.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_ENTRIES = 512;
    localparam int COORD_BITS  = 16;
    localparam int LABEL_BITS  = 8;

    localparam int INDEX_BITS  = $clog2(MAX_ENTRIES);
    localparam int COUNT_BITS  = $clog2(MAX_ENTRIES + 1);
    localparam int DIST_BITS   = 2 * COORD_BITS + 1;
    localparam int SQ_BITS     = 2 * COORD_BITS;

    // stream payload layout, lowest field first
    localparam int IN_FIELD_BITS  = INDEX_BITS + 2 * COORD_BITS + LABEL_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = INDEX_BITS + LABEL_BITS + DIST_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int IN_IDX_LSB  = 0;
    localparam int IN_X_LSB    = IN_IDX_LSB + INDEX_BITS;
    localparam int IN_Y_LSB    = IN_X_LSB + COORD_BITS;
    localparam int IN_LAB_LSB  = IN_Y_LSB + COORD_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(MAX_ENTRIES);

    // request kinds carried on tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [LABEL_BITS-1:0] label;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } t_entry;

    typedef struct packed {
        logic load_wr;     // write the table entry from the input item
        logic scan_start;  // capture query point, clear best
        logic scan_step;   // read one entry, advance scan address
        logic out_zero;    // load an all-zero result
        logic out_best;    // load the best match as result
    } t_cmd;

    typedef struct packed {
        logic out_free;    // output register empty or being taken
        logic count_zero;  // vertex count is zero
        logic scan_last;   // current scan address is the last entry
        logic pipe_empty;  // no entry in flight in the distance pipeline
    } t_status;

endpackage

// File: rtl/nps_ctrl.sv
// ----------------------------------------------------------------------------
// nps_ctrl
// Controller state machine: accepts items, sequences the table scan and
// hands results to the output register.
// ----------------------------------------------------------------------------
module nps_ctrl
    import nps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_req_type,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_req_type == REQ_QUERY) && !i_status.count_zero) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_status.out_free;
                if (w_accept) begin
                    if (i_req_type == REQ_LOAD) begin
                        o_cmd.load_wr  = 1'b1;
                        o_cmd.out_zero = 1'b1;
                    end else if (i_status.count_zero) begin
                        o_cmd.out_zero = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd = '0;
            end
            ST_DONE: begin
                o_cmd.out_best = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/nps_dpath.sv
// ----------------------------------------------------------------------------
// nps_dpath
// Datapath: point table, scan address, distance pipeline (table read and
// squared differences), running minimum and output register.
// ----------------------------------------------------------------------------
module nps_dpath
    import nps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic [COUNT_BITS-1:0] i_cfg_wdata,
    input  logic [INDEX_BITS-1:0] i_entry_index,
    input  logic [COORD_BITS-1:0] i_coord_x,
    input  logic [COORD_BITS-1:0] i_coord_y,
    input  logic [LABEL_BITS-1:0] i_entry_label,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [INDEX_BITS-1:0] o_nearest_index,
    output logic [LABEL_BITS-1:0] o_nearest_label,
    output logic [DIST_BITS-1:0]  o_nearest_dist_sq
);

    t_entry                r_mem [MAX_ENTRIES];
    t_entry                r_rd_data;

    logic [COUNT_BITS-1:0] r_vertex_count;
    logic [COUNT_BITS-1:0] w_eff_count;
    logic [INDEX_BITS-1:0] r_scan_addr;

    logic [COORD_BITS-1:0] r_qx;
    logic [COORD_BITS-1:0] r_qy;

    // stage 1: table read
    logic                  r_v1;
    logic [INDEX_BITS-1:0] r_idx1;
    // stage 2: squared differences
    logic                  r_v2;
    logic [INDEX_BITS-1:0] r_idx2;
    logic [LABEL_BITS-1:0] r_lab2;
    logic [SQ_BITS-1:0]    r_sqx;
    logic [SQ_BITS-1:0]    r_sqy;

    logic [COORD_BITS-1:0] w_dx;
    logic [COORD_BITS-1:0] w_dy;
    logic [DIST_BITS-1:0]  w_dist;
    logic                  w_better;

    logic                  r_have;
    logic [DIST_BITS-1:0]  r_best;
    logic [INDEX_BITS-1:0] r_best_idx;
    logic [LABEL_BITS-1:0] r_best_lab;

    logic                  r_out_valid;
    logic [INDEX_BITS-1:0] r_out_idx;
    logic [LABEL_BITS-1:0] r_out_lab;
    logic [DIST_BITS-1:0]  r_out_dist;

    // counts above the table size saturate
    assign w_eff_count = (r_vertex_count > COUNT_RESET) ? COUNT_RESET : r_vertex_count;

    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.count_zero = (r_vertex_count == '0);
    assign o_status.scan_last  = (COUNT_BITS'(r_scan_addr) == (w_eff_count - 1'b1));
    assign o_status.pipe_empty = !r_v1 && !r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    // table: one write port for loads, one registered read for the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem[i_entry_index] <= '{label: i_entry_label, y: i_coord_y, x: i_coord_x};
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= r_mem[r_scan_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_scan_addr <= '0;
            end else if (i_cmd.scan_step) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
            r_v1 <= i_cmd.scan_step;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_qx <= i_coord_x;
            r_qy <= i_coord_y;
        end
        r_idx1 <= r_scan_addr;
    end

    assign w_dx = (r_qx > r_rd_data.x) ? (r_qx - r_rd_data.x) : (r_rd_data.x - r_qx);
    assign w_dy = (r_qy > r_rd_data.y) ? (r_qy - r_rd_data.y) : (r_rd_data.y - r_qy);

    always_ff @(posedge i_clk) begin
        r_sqx  <= SQ_BITS'(w_dx) * SQ_BITS'(w_dx);
        r_sqy  <= SQ_BITS'(w_dy) * SQ_BITS'(w_dy);
        r_idx2 <= r_idx1;
        r_lab2 <= r_rd_data.label;
    end

    // strict less-than keeps the lowest index on a tie
    assign w_dist   = DIST_BITS'(r_sqx) + DIST_BITS'(r_sqy);
    assign w_better = r_v2 && (!r_have || (w_dist < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_have <= 1'b0;
        end else if (w_better) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_better) begin
            r_best     <= w_dist;
            r_best_idx <= r_idx2;
            r_best_lab <= r_lab2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_zero || i_cmd.out_best) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_zero) begin
            r_out_idx  <= '0;
            r_out_lab  <= '0;
            r_out_dist <= '0;
        end else if (i_cmd.out_best) begin
            r_out_idx  <= r_best_idx;
            r_out_lab  <= r_best_lab;
            r_out_dist <= r_best;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_nearest_index   = r_out_idx;
    assign o_nearest_label   = r_out_lab;
    assign o_nearest_dist_sq = r_out_dist;

endmodule

// File: rtl/nearest_point_search.sv
// ----------------------------------------------------------------------------
// nearest_point_search
// Brute-force nearest neighbor search over a table of labeled 2-D points.
//
// channel     dir  content
// s_axis      in   tuser: req_type; tdata: entry_index, coord_x, coord_y,
//                  entry_label
// m_axis      out  tdata: nearest_index, nearest_label, nearest_dist_sq
// cfg         in   i_cfg_we / i_cfg_wdata: vertex_count
//
// A load's all-zero result is in the output register in the cycle after it is
// accepted. A query reads one table entry per cycle from the table's read
// port and scans min(vertex_count, 512) entries; when vertex_count is zero it
// returns an all-zero result without a scan. One item is in work at a
// time. Reset is synchronous, active low, and sets vertex_count to 512; the
// table is not cleared. A stalled output holds the result and blocks input.
// ----------------------------------------------------------------------------
module nearest_point_search
    import nps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // entry_index, coord_x, coord_y,
                                                     // entry_label, zero pad
    input  logic                     s_axis_tuser,   // req_type
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // nearest_index, nearest_label,
                                                     // nearest_dist_sq, zero pad
    input  logic                     i_cfg_we,
    input  logic [COUNT_BITS-1:0]    i_cfg_wdata
);

    t_cmd                  w_cmd;
    t_status               w_status;
    logic [INDEX_BITS-1:0] w_idx;
    logic [LABEL_BITS-1:0] w_lab;
    logic [DIST_BITS-1:0]  w_dist;

    nps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    nps_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_entry_index     (s_axis_tdata[IN_IDX_LSB +: INDEX_BITS]),
        .i_coord_x         (s_axis_tdata[IN_X_LSB +: COORD_BITS]),
        .i_coord_y         (s_axis_tdata[IN_Y_LSB +: COORD_BITS]),
        .i_entry_label     (s_axis_tdata[IN_LAB_LSB +: LABEL_BITS]),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_nearest_index   (w_idx),
        .o_nearest_label   (w_lab),
        .o_nearest_dist_sq (w_dist)
    );

    assign m_axis_tdata = OUT_DATA_BITS'({w_dist, w_lab, w_idx});

    // never overwrite a result that has not been taken
    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_zero || w_cmd.out_best) |-> w_status.out_free)
        else $error("result loaded while output register is occupied");

    // an item is taken only with the distance pipeline empty
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> w_status.pipe_empty)
        else $error("item accepted while a scan is in flight");

    // input stays closed in the cycle after each scan step
    a_scan_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_step |=> !s_axis_tready)
        else $error("input ready during a scan");

    // the best result is handed over only after the last compare
    a_best_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_best |-> (w_status.pipe_empty && !w_cmd.scan_step))
        else $error("best result taken before the scan drained");

endmodule
